[rtl/core/hmkv_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed-list min-heap package
// Sizes, codes, payload structs and helpers used by the heap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hmkv_pkg;

  // Heap geometry.
  localparam int unsigned HEAP_DEPTH     = 64;
  localparam int unsigned VALUES_PER_KEY = 8;

  localparam int unsigned IDX_W   = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CH_W    = IDX_W + 2;
  localparam int unsigned VCNT_W  = $clog2(VALUES_PER_KEY + 1);
  localparam int unsigned VDEPTH  = HEAP_DEPTH * VALUES_PER_KEY;
  localparam int unsigned VADDR_W = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_PEEK    = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_CHANGE  = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_HEAP_FULL = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_e;

  // Command transaction payload.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key;
    logic signed [31:0] new_key;
    logic signed [31:0] item_value;
  } cmd_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               has_value;
    logic               last;
  } result_t;

  // One heap slot: its key, the length of its list, and the list slot it owns.
  typedef struct packed {
    logic signed [31:0] key;
    logic [VCNT_W-1:0]  cnt;
    logic [IDX_W-1:0]   id;
  } node_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_INS_RD, S_INS_NEW,
    S_PK_RD, S_PK_HD, S_STREAM, S_DRAIN, S_MERGE_CP, S_MERGE_ND,
    S_REM_RD, S_REM, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_RESP
  } state_e;

  // Signed key compare: a strictly greater than b.
  function automatic logic key_gt(input logic signed [31:0] a,
                                  input logic signed [31:0] b);
    return a > b;
  endfunction

  // Address of entry k of the value list owned by slot id.
  function automatic logic [VADDR_W-1:0] vaddr(input logic [IDX_W-1:0] id,
                                               input logic [VCNT_W-1:0] k);
    logic [31:0] a;
    a = 32'(id) * 32'(VALUES_PER_KEY) + 32'(k);
    return a[VADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/hmkv_ram.sv]
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hmkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/min_heap_keyed_value_lists_unit.sv]
// ----------------------------------------------------------------------------
// Keyed-list min-heap unit
// Binary min-heap of unique signed keys, each owning an ordered value list.
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; one command runs at
// a time. Results appear for one cycle each with strobe high and cannot be
// stalled. Insert and change-key first scan the key memory, one slot a
// cycle, then sift the heap up or down. Peek streams the root's list
// values; extract adds the removal and sift-down of the root. Every heap step
// is a read of the node memory, whose read data is registered. After reset
// the unit assigns a list slot to each heap slot, with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_keyed_value_lists_unit
  import hmkv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         strobe,
  output result_t      result
);

  state_e state, state_next;

  // Node memory ports.
  logic               n_we;
  logic [IDX_W-1:0]   n_waddr, n_raddr;
  node_t              n_wdata, n_rdata;
  logic [$bits(node_t)-1:0] n_rdata_raw;

  // Value memory ports.
  logic               v_we;
  logic [VADDR_W-1:0] v_waddr, v_raddr;
  logic [31:0]        v_wdata, v_rdata;

  // Control and datapath registers.
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   init_addr;
  cmd_t               cmd_r;
  logic [CNT_W-1:0]   scan_addr;
  logic               sc_v;
  logic               fi, fj;
  logic [IDX_W-1:0]   pi, pj;
  node_t              ei, ej;
  node_t              ent;
  node_t              lchild;
  logic               rv;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W-1:0]   freed_id;
  logic [VCNT_W-1:0]  jcnt, mk;
  logic               sv_v, sv_last;
  logic               mw_v;
  logic [VADDR_W-1:0] mw_addr;
  status_e            st;

  // Derived heap positions.
  logic [IDX_W-1:0]   par;
  logic [CH_W-1:0]    lch, rch, cnt_ext;
  logic               up_move, use_l, use_r;
  logic signed [31:0] best_key;
  node_t              dn_child;
  logic [IDX_W-1:0]   dn_pos;
  logic [VCNT_W:0]    merge_sum;

  assign n_rdata  = node_t'(n_rdata_raw);
  assign par      = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign lch      = CH_W'({pos, 1'b1});
  assign rch      = lch + CH_W'(1);
  assign cnt_ext  = CH_W'(count);
  assign up_move  = key_gt(n_rdata.key, ent.key);
  assign use_l    = key_gt(ent.key, lchild.key);
  assign best_key = use_l ? lchild.key : ent.key;
  assign use_r    = rv && key_gt(best_key, n_rdata.key);
  assign dn_child = use_r ? n_rdata : lchild;
  assign dn_pos   = use_r ? rch[IDX_W-1:0] : lch[IDX_W-1:0];
  assign merge_sum = (VCNT_W+1)'(ei.cnt) + (VCNT_W+1)'(ej.cnt);

  hmkv_ram #(.WIDTH($bits(node_t)), .DEPTH(HEAP_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata_raw)
  );

  hmkv_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_val_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_addr == IDX_W'(HEAP_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (cmd.operation == OP_PEEK || cmd.operation == OP_EXTRACT) begin
            state_next = (count == '0) ? S_RESP : S_PK_RD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_addr >= count && !sc_v) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (cmd_r.operation == OP_INSERT) begin
          if (!fi && count < CNT_W'(HEAP_DEPTH)) state_next = S_INS_RD;
          else                                   state_next = S_RESP;
        end else begin
          if (!fi || cmd_r.new_key == cmd_r.key)            state_next = S_RESP;
          else if (fj && merge_sum > (VCNT_W+1)'(VALUES_PER_KEY)) state_next = S_RESP;
          else if (fj)                                       state_next = S_MERGE_CP;
          else                                               state_next = S_UP_RD;
        end
      end
      S_INS_RD:  state_next = S_INS_NEW;
      S_INS_NEW: state_next = S_UP_RD;
      S_PK_RD:   state_next = S_PK_HD;
      S_PK_HD:   state_next = S_STREAM;
      S_STREAM: begin
        if (jcnt == ei.cnt - VCNT_W'(1)) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = (cmd_r.operation == OP_EXTRACT) ? S_REM_RD : S_IDLE;
      end
      S_MERGE_CP: begin
        if (mk == ei.cnt && !mw_v) state_next = S_MERGE_ND;
      end
      S_MERGE_ND: state_next = S_REM_RD;
      S_REM_RD:   state_next = S_REM;
      S_REM: begin
        state_next = (CNT_W'(pos) == count - CNT_W'(1)) ? S_RESP : S_UP_RD;
      end
      S_UP_RD:  state_next = (pos == '0) ? S_DN_RDL : S_UP_CMP;
      S_UP_CMP: state_next = up_move ? S_UP_RD : S_DN_RDL;
      S_DN_RDL: state_next = (lch >= cnt_ext) ? S_RESP : S_DN_RDR;
      S_DN_RDR: state_next = S_DN_CMP;
      S_DN_CMP: state_next = (use_l || use_r) ? S_DN_RDL : S_RESP;
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory access and result outputs.
  always_comb begin
    n_we    = 1'b0;
    n_waddr = pos;
    n_wdata = ent;
    n_raddr = '0;
    v_we    = 1'b0;
    v_waddr = mw_addr;
    v_wdata = v_rdata;
    v_raddr = '0;
    unique case (state)
      S_INIT: begin
        n_we    = 1'b1;
        n_waddr = init_addr;
        n_wdata = '{key: '0, cnt: '0, id: init_addr};
      end
      S_SCAN:  n_raddr = scan_addr[IDX_W-1:0];
      S_DECIDE: begin
        if (cmd_r.operation == OP_INSERT && fi &&
            ei.cnt < VCNT_W'(VALUES_PER_KEY)) begin
          v_we    = 1'b1;
          v_waddr = vaddr(ei.id, ei.cnt);
          v_wdata = cmd_r.item_value;
          n_we    = 1'b1;
          n_waddr = pi;
          n_wdata = '{key: ei.key, cnt: ei.cnt + VCNT_W'(1), id: ei.id};
        end
      end
      S_INS_RD: n_raddr = count[IDX_W-1:0];
      S_INS_NEW: begin
        v_we    = 1'b1;
        v_waddr = vaddr(n_rdata.id, '0);
        v_wdata = cmd_r.item_value;
      end
      S_PK_RD:  n_raddr = '0;
      S_STREAM: v_raddr = vaddr(ei.id, jcnt);
      S_MERGE_CP: begin
        v_raddr = vaddr(ei.id, mk);
        v_we    = mw_v;
      end
      S_MERGE_ND: begin
        n_we    = 1'b1;
        n_waddr = pj;
        n_wdata = '{key: ej.key, cnt: VCNT_W'(merge_sum), id: ej.id};
      end
      S_REM_RD: n_raddr = IDX_W'(count - CNT_W'(1));
      S_REM: begin
        // The emptied last slot keeps the freed list slot.
        n_we    = 1'b1;
        n_waddr = IDX_W'(count - CNT_W'(1));
        n_wdata = '{key: n_rdata.key, cnt: n_rdata.cnt, id: freed_id};
      end
      S_UP_RD: n_raddr = par;
      S_UP_CMP: begin
        n_we    = up_move;
        n_wdata = n_rdata;
      end
      S_DN_RDL: begin
        n_raddr = lch[IDX_W-1:0];
        n_we    = (lch >= cnt_ext);
      end
      S_DN_RDR: n_raddr = rch[IDX_W-1:0];
      S_DN_CMP: begin
        n_we    = 1'b1;
        n_wdata = (use_l || use_r) ? dn_child : ent;
      end
      default: begin
      end
    endcase

    // An extract that streamed its values ends without a status result.
    busy             = (state != S_IDLE);
    strobe           = sv_v || ((state == S_RESP) &&
                                !(cmd_r.operation == OP_EXTRACT && st == ST_OK));
    result.out_value = sv_v ? v_rdata : '0;
    result.status    = sv_v ? ST_OK : st;
    result.has_value = sv_v;
    result.last      = sv_v ? sv_last : 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= '0;
      init_addr <= '0;
      sc_v      <= 1'b0;
      sv_v      <= 1'b0;
      mw_v      <= 1'b0;
    end else begin
      state <= state_next;
      sv_v  <= (state == S_STREAM);
      if (state == S_INIT)    init_addr <= init_addr + IDX_W'(1);
      if (state == S_INS_NEW) count <= count + CNT_W'(1);
      if (state == S_REM)     count <= count - CNT_W'(1);
      if (state == S_SCAN)    sc_v <= (scan_addr < count);
      else                    sc_v <= 1'b0;
      if (state == S_MERGE_CP) mw_v <= (mk < ei.cnt);
      else                     mw_v <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    sv_last <= (jcnt == ei.cnt - VCNT_W'(1));
    case (state)
      S_IDLE: begin
        cmd_r     <= cmd;
        scan_addr <= '0;
        fi        <= 1'b0;
        fj        <= 1'b0;
        st        <= (count == '0) ? ST_MISS : ST_OK;
      end
      S_SCAN: begin
        if (scan_addr < count) scan_addr <= scan_addr + CNT_W'(1);
        if (sc_v && n_rdata.key == cmd_r.key) begin
          fi <= 1'b1;
          pi <= IDX_W'(scan_addr - CNT_W'(1));
          ei <= n_rdata;
        end
        if (sc_v && n_rdata.key == cmd_r.new_key) begin
          fj <= 1'b1;
          pj <= IDX_W'(scan_addr - CNT_W'(1));
          ej <= n_rdata;
        end
      end
      S_DECIDE: begin
        mk <= '0;
        if (cmd_r.operation == OP_INSERT) begin
          if (fi) begin
            st <= (ei.cnt >= VCNT_W'(VALUES_PER_KEY)) ? ST_LIST_FULL : ST_OK;
          end else begin
            st <= (count >= CNT_W'(HEAP_DEPTH)) ? ST_HEAP_FULL : ST_OK;
          end
        end else if (!fi) begin
          st <= ST_MISS;
        end else if (cmd_r.new_key == cmd_r.key) begin
          st <= ST_OK;
        end else if (fj) begin
          st <= (merge_sum > (VCNT_W+1)'(VALUES_PER_KEY)) ? ST_LIST_FULL : ST_OK;
        end else begin
          st  <= ST_OK;
          ent <= '{key: cmd_r.new_key, cnt: ei.cnt, id: ei.id};
          pos <= pi;
        end
      end
      S_INS_NEW: begin
        ent <= '{key: cmd_r.key, cnt: VCNT_W'(1), id: n_rdata.id};
        pos <= count[IDX_W-1:0];
      end
      S_PK_HD: begin
        ei   <= n_rdata;
        jcnt <= '0;
      end
      S_STREAM: jcnt <= jcnt + VCNT_W'(1);
      S_DRAIN: begin
        pos      <= '0;
        freed_id <= ei.id;
      end
      S_MERGE_CP: begin
        mw_addr <= vaddr(ej.id, ej.cnt + mk);
        if (mk < ei.cnt) mk <= mk + VCNT_W'(1);
      end
      S_MERGE_ND: begin
        pos      <= pi;
        freed_id <= ei.id;
      end
      S_REM:    ent <= n_rdata;
      S_UP_CMP: if (up_move) pos <= par;
      S_DN_RDR: begin
        lchild <= n_rdata;
        rv     <= (rch < cnt_ext);
      end
      S_DN_CMP: if (use_l || use_r) pos <= dn_pos;
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  // The heap never holds more nodes than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HEAP_DEPTH))
    else $error("node count exceeds heap depth");

  // A parent compare is only made below the root.
  a_up_not_root: assert property (@(posedge clk) disable iff (rst)
    state == S_UP_CMP |-> pos != '0)
    else $error("sift-up compare at the root");

  // No result is given while a new command can be taken.
  a_no_idle_result: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !strobe)
    else $error("result strobe while idle");

  // The final result of a transaction is never followed by another at once.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("result after the final result");
`endif

endmodule

`default_nettype wire
